### sv/slpg_pkg.sv
// Shared types, constants and helpers for the status LED pattern generator.
package slpg_pkg;

  // Constant divisors, all below 2048, and their floor(2^32/d) reciprocals
  localparam int unsigned DSR_W = 11;
  localparam int unsigned RCP_W = 27;

  localparam logic [DSR_W-1:0] DIV_60   = 11'd60;
  localparam logic [DSR_W-1:0] DIV_500  = 11'd500;
  localparam logic [DSR_W-1:0] DIV_700  = 11'd700;
  localparam logic [DSR_W-1:0] DIV_1400 = 11'd1400;
  localparam logic [DSR_W-1:0] DIV_1500 = 11'd1500;

  localparam logic [RCP_W-1:0] RCP_60   = 27'd71582788;
  localparam logic [RCP_W-1:0] RCP_500  = 27'd8589934;
  localparam logic [RCP_W-1:0] RCP_700  = 27'd6135667;
  localparam logic [RCP_W-1:0] RCP_1400 = 27'd3067833;
  localparam logic [RCP_W-1:0] RCP_1500 = 27'd2863311;

  // Register file
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_BRIGHTNESS = 1'b0;
  localparam logic [7:0] BRIGHT_RESET = 8'd64;

  // Network state codes
  localparam logic [2:0] NET_BOOT    = 3'd0;
  localparam logic [2:0] NET_BUTTON  = 3'd1;
  localparam logic [2:0] NET_STATION = 3'd2;
  localparam logic [2:0] NET_PROV    = 3'd3;
  localparam logic [2:0] NET_ERROR   = 3'd4;

  // Item kinds
  localparam logic FUNC_RENDER   = 1'b0;
  localparam logic FUNC_ACTIVITY = 1'b1;

  typedef enum logic [2:0] {
    PAT_OFFLINE = 3'd0,
    PAT_CLIENT  = 3'd1,
    PAT_BOOT    = 3'd2,
    PAT_BUTTON  = 3'd3,
    PAT_STATION = 3'd4,
    PAT_PROV    = 3'd5,
    PAT_ERROR   = 3'd6
  } pattern_t;

  typedef struct packed {
    logic             start;
    logic [31:0]      dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [31:0]      quot;
    logic [DSR_W-1:0] rem;
  } div_rsp_t;

  // x / 255 for x up to 255*255, by reciprocal shift with correction
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'(x >> 8) + 17'd1;
    return s[15:8];
  endfunction

endpackage

### sv/slpg_in_if.sv
// Render and activity word channel into the pattern generator.
interface slpg_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] now_ms;
  logic [2:0]  net_state;
  logic        client_connected;
  logic        offline_mode;

  modport source (output valid, func, now_ms, net_state, client_connected, offline_mode,
                  input ready);
  modport sink (input valid, func, now_ms, net_state, client_connected, offline_mode,
                output ready);
endinterface

### sv/slpg_out_if.sv
// Colour word channel out of the pattern generator.
interface slpg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

### sv/status_led_pattern_generator.sv
// Status LED pattern generator: picks, scales and de-duplicates the RGB colour.
// Activity word: accepted with no result. Render word: a reciprocal division of the time,
// a second division for the level in the button window pattern, then three channel scalings
// on one multiplier, then the emit state loads the result register; a stalled result holds
// the emit state. A new word is taken only in the idle state, once the last render is through.
// Reset (rst, synchronous): brightness 64, stored colour cleared, so the first render emits.
module status_led_pattern_generator #(
  parameter int unsigned ACTIVITY_HOLD = 150
) (
  input  logic                         clk,
  input  logic                         rst,
  slpg_in_if.sink                      item,
  slpg_out_if.source                   result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [slpg_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam logic [31:0] HOLD = 32'(ACTIVITY_HOLD);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_LVL  = 5'b00100,
    S_DIM  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t             state, state_next;
  slpg_pkg::pattern_t pat, pat_in;
  logic               pat_ok;
  logic               recent;
  logic [31:0]        last_act;
  logic [31:0]        since;
  logic [7:0]         brightness;
  logic [1:0]         ch;
  logic [7:0]         base [3];
  logic [7:0]         scaled [3];
  logic [7:0]         last_red, last_green, last_blue;
  logic               last_valid;
  logic               out_valid;
  logic [7:0]         out_red, out_green, out_blue;
  logic               accept, render_go, out_load, same;
  logic [7:0]         col_r, col_g, col_b;
  logic [10:0]        lvl_arg;
  logic [18:0]        lvl_num;
  logic [15:0]        m_prod;
  logic [7:0]         m_lvl;
  logic [15:0]        dim_prod;
  logic [slpg_pkg::DSR_W-1:0] div_in;
  logic               pip;

  slpg_pkg::div_req_t div_req;
  slpg_pkg::div_rsp_t div_rsp;

  slpg_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .brightness (brightness)
  );

  slpg_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign since      = item.now_ms - last_act;

  // Pick the pattern: offline first, then client, then network state
  always_comb begin
    pat_ok = 1'b1;
    pat_in = slpg_pkg::PAT_BOOT;
    if (item.offline_mode) begin
      pat_in = slpg_pkg::PAT_OFFLINE;
    end else if (item.client_connected) begin
      pat_in = slpg_pkg::PAT_CLIENT;
    end else begin
      unique case (item.net_state)
        slpg_pkg::NET_BOOT:    pat_in = slpg_pkg::PAT_BOOT;
        slpg_pkg::NET_BUTTON:  pat_in = slpg_pkg::PAT_BUTTON;
        slpg_pkg::NET_STATION: pat_in = slpg_pkg::PAT_STATION;
        slpg_pkg::NET_PROV:    pat_in = slpg_pkg::PAT_PROV;
        slpg_pkg::NET_ERROR:   pat_in = slpg_pkg::PAT_ERROR;
        default:               pat_ok = 1'b0;
      endcase
    end
  end

  always_comb begin
    unique case (pat_in)
      slpg_pkg::PAT_OFFLINE: div_in = slpg_pkg::DIV_1500;
      slpg_pkg::PAT_CLIENT:  div_in = slpg_pkg::DIV_60;
      slpg_pkg::PAT_BUTTON:  div_in = slpg_pkg::DIV_1400;
      default:               div_in = slpg_pkg::DIV_500;
    endcase
  end

  assign render_go = accept && item.func == slpg_pkg::FUNC_RENDER && pat_ok;

  // Triangle level: ph*255 on the rising half, (1400-ph)*255 on the falling half
  assign lvl_arg = (div_rsp.rem < 11'd700) ? div_rsp.rem : 11'd1400 - div_rsp.rem;
  assign lvl_num = 19'(lvl_arg) * 19'd255;
  assign m_prod  = 16'(div_rsp.quot[7:0]) * 16'd150;
  assign m_lvl   = slpg_pkg::div255(m_prod);

  assign div_req.start    = render_go ||
                            (state == S_DIV && div_rsp.done && pat == slpg_pkg::PAT_BUTTON);
  assign div_req.dividend = (state == S_IDLE) ? item.now_ms : 32'(lvl_num);
  assign div_req.divisor  = (state == S_IDLE) ? div_in : slpg_pkg::DIV_700;

  // Base colour from the time quotient bit and phase remainder
  assign pip = (div_rsp.rem < 11'd90) || (div_rsp.rem >= 11'd210 && div_rsp.rem < 11'd300);

  always_comb begin
    col_r = 8'd0;
    col_g = 8'd0;
    col_b = 8'd0;
    case (pat)
      slpg_pkg::PAT_OFFLINE: begin
        col_r = pip ? 8'd255 : 8'd0;
        col_g = pip ? 8'd60 : 8'd0;
      end
      slpg_pkg::PAT_CLIENT: begin
        if (recent) begin
          col_g = div_rsp.quot[0] ? 8'd220 : 8'd70;
          col_b = div_rsp.quot[0] ? 8'd90 : 8'd25;
        end else begin
          col_g = 8'd90;
        end
      end
      slpg_pkg::PAT_BOOT: begin
        col_r = div_rsp.quot[0] ? 8'd90 : 8'd0;
        col_g = div_rsp.quot[0] ? 8'd55 : 8'd0;
      end
      slpg_pkg::PAT_STATION: col_b = div_rsp.quot[0] ? 8'd110 : 8'd10;
      slpg_pkg::PAT_PROV: begin
        col_g = div_rsp.quot[0] ? 8'd130 : 8'd0;
        col_b = div_rsp.quot[0] ? 8'd130 : 8'd0;
      end
      slpg_pkg::PAT_ERROR: col_r = div_rsp.quot[0] ? 8'd140 : 8'd0;
      default: begin
        col_r = 8'd0;
      end
    endcase
  end

  assign dim_prod = 16'(base[ch]) * 16'(brightness);

  assign same = last_valid && scaled[0] == last_red && scaled[1] == last_green &&
                scaled[2] == last_blue;
  assign out_load = (state == S_EMIT) && !same && (!out_valid || result.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (render_go) state_next = S_DIV;
      S_DIV: begin
        if (div_rsp.done) state_next = (pat == slpg_pkg::PAT_BUTTON) ? S_LVL : S_DIM;
      end
      S_LVL:  if (div_rsp.done) state_next = S_DIM;
      S_DIM:  if (ch == 2'd2) state_next = S_EMIT;
      S_EMIT: if (same || out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      last_act   <= '0;
      last_red   <= '0;
      last_green <= '0;
      last_blue  <= '0;
      last_valid <= 1'b0;
      out_valid  <= 1'b0;
      ch         <= '0;
    end else begin
      state <= state_next;
      if (accept && item.func == slpg_pkg::FUNC_ACTIVITY) begin
        last_act <= item.now_ms;
      end
      if (state != S_DIM) begin
        ch <= '0;
      end else begin
        ch <= ch + 2'd1;
      end
      if (out_load) begin
        last_red   <= scaled[0];
        last_green <= scaled[1];
        last_blue  <= scaled[2];
        last_valid <= 1'b1;
      end
      // Hold the word until taken; a new load may replace it in the same cycle
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (render_go) begin
      pat    <= pat_in;
      recent <= since < HOLD;
    end
    if (state == S_DIV && div_rsp.done && pat != slpg_pkg::PAT_BUTTON) begin
      base[0] <= col_r;
      base[1] <= col_g;
      base[2] <= col_b;
    end
    if (state == S_LVL && div_rsp.done) begin
      base[0] <= m_lvl;
      base[1] <= 8'd0;
      base[2] <= m_lvl;
    end
    if (state == S_DIM) begin
      scaled[ch] <= slpg_pkg::div255(dim_prod);
    end
    if (out_load) begin
      out_red   <= scaled[0];
      out_green <= scaled[1];
      out_blue  <= scaled[2];
    end
  end

  assign result.valid = out_valid;
  assign result.red   = out_red;
  assign result.green = out_green;
  assign result.blue  = out_blue;

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV || state == S_LVL))
    else $error("divider finished outside a division state");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("colour word raised outside the emit state");

  a_out_has_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_valid)
    else $error("colour word pending without a stored colour");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (rst)
    out_load |=> state == S_IDLE)
    else $error("sequencer did not return to idle after a colour load");

endmodule

### sv/slpg_regs.sv
// APB register block holding the master brightness.
module slpg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [slpg_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [7:0]                   brightness
);

  logic [slpg_pkg::ADDR_W-3:0] idx;
  logic                        wr;

  assign idx    = paddr[slpg_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= slpg_pkg::BRIGHT_RESET;
    end else if (wr && idx == slpg_pkg::REG_BRIGHTNESS) begin
      brightness <= pwdata[7:0];
    end
  end

  always_comb begin
    unique case (idx)
      slpg_pkg::REG_BRIGHTNESS: prdata = {24'd0, brightness};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

### sv/slpg_divider.sv
// Constant divider: reciprocal multiply, back-multiply and one correction step.
module slpg_divider (
  input  logic                clk,
  input  logic                rst,
  input  slpg_pkg::div_req_t  req,
  output slpg_pkg::div_rsp_t  rsp
);

  localparam int unsigned PROD_W = slpg_pkg::RCP_W + 32;

  logic                         run1, run2, run3;
  logic                         done;
  logic [31:0]                  dvd;
  logic [slpg_pkg::DSR_W-1:0]   dsr;
  logic [slpg_pkg::RCP_W-1:0]   rcp;
  logic [slpg_pkg::RCP_W-1:0]   rcp_sel;
  logic [PROD_W-1:0]            prod;
  logic [slpg_pkg::RCP_W-1:0]   qe;
  logic [31:0]                  back;
  logic [31:0]                  rfull;
  logic [slpg_pkg::DSR_W:0]     rraw;
  logic                         ge;
  logic [slpg_pkg::DSR_W:0]     diff;
  logic [31:0]                  quot;
  logic [slpg_pkg::DSR_W-1:0]   rem;

  always_comb begin
    unique case (req.divisor)
      slpg_pkg::DIV_60:   rcp_sel = slpg_pkg::RCP_60;
      slpg_pkg::DIV_500:  rcp_sel = slpg_pkg::RCP_500;
      slpg_pkg::DIV_700:  rcp_sel = slpg_pkg::RCP_700;
      slpg_pkg::DIV_1400: rcp_sel = slpg_pkg::RCP_1400;
      slpg_pkg::DIV_1500: rcp_sel = slpg_pkg::RCP_1500;
      default:            rcp_sel = '0;
    endcase
  end

  // The estimate from floor(2^32/d) falls short of the quotient by at most one,
  // so the raw remainder stays below twice the divisor
  assign prod  = PROD_W'(dvd) * PROD_W'(rcp);
  assign back  = 32'(qe) * 32'(dsr);
  assign rfull = dvd - back;
  assign ge    = rraw >= {1'b0, dsr};
  assign diff  = rraw - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run1 <= 1'b0;
      run2 <= 1'b0;
      run3 <= 1'b0;
      done <= 1'b0;
    end else begin
      run1 <= req.start;
      run2 <= run1;
      run3 <= run2;
      done <= run3;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rcp <= rcp_sel;
    end
    if (run1) begin
      qe <= prod[PROD_W-1:32];
    end
    if (run2) begin
      rraw <= rfull[slpg_pkg::DSR_W:0];
    end
    // Fold the short estimate back in
    if (run3) begin
      quot <= 32'(qe) + (ge ? 32'd1 : 32'd0);
      rem  <= ge ? diff[slpg_pkg::DSR_W-1:0] : rraw[slpg_pkg::DSR_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

### tb/tb_status_led_pattern_generator.sv
// Testbench for the status LED pattern generator: directed and random words, colour predictor.
module tb_status_led_pattern_generator;

  localparam int unsigned HOLD_MS       = 150;
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam int unsigned LIMIT_CYCLES  = 800000;
  localparam int unsigned PHASE_WORDS   = 147;
  localparam logic [slpg_pkg::ADDR_W-1:0] BRIGHT_ADDR   = {slpg_pkg::REG_BRIGHTNESS, 2'b00};
  localparam logic [slpg_pkg::ADDR_W-1:0] UNMAPPED_ADDR = {~slpg_pkg::REG_BRIGHTNESS, 2'b00};

  typedef struct packed {
    logic        func;
    logic [31:0] now_ms;
    logic [2:0]  net_state;
    logic        client;
    logic        offline;
  } led_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [slpg_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  slpg_in_if  item_ch ();
  slpg_out_if colour_ch ();

  status_led_pattern_generator #(
    .ACTIVITY_HOLD(HOLD_MS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (colour_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state
  logic [7:0]  bright_lvl;
  logic [31:0] activity_ms;
  colour_t     shown;
  logic        shown_valid;

  led_word_t   words_to_send[$];
  colour_t     colours_due[$];
  led_word_t   in_flight;
  colour_t     want;
  logic [31:0] sim_ms;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned cycle_count = 0;
  int          errors = 0;

  always #5 clk = ~clk;

  function automatic logic [7:0] scale_level(input logic [7:0] v);
    return 8'((16'(v) * 16'(bright_lvl)) / 16'd255);
  endfunction

  function automatic void check_level(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endfunction

  task automatic predict_colour(input led_word_t w);
    logic        fast;
    logic        slow;
    logic        lit;
    logic [31:0] ph;
    logic [31:0] lvl;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    colour_t     c;
    if (w.func == slpg_pkg::FUNC_ACTIVITY) begin
      activity_ms = w.now_ms;
      return;
    end
    fast = ((w.now_ms / 32'd60) & 32'd1) != 0;
    slow = ((w.now_ms / 32'd500) & 32'd1) != 0;
    lit = 1'b1;
    r = '0;
    g = '0;
    b = '0;
    if (w.offline) begin
      ph = w.now_ms % 32'd1500;
      if (ph < 90 || (ph >= 210 && ph < 300)) begin
        r = 8'd255;
        g = 8'd60;
      end
    end else if (w.client) begin
      if (32'(w.now_ms - activity_ms) < HOLD_MS) begin
        g = fast ? 8'd220 : 8'd70;
        b = fast ? 8'd90 : 8'd25;
      end else begin
        g = 8'd90;
      end
    end else begin
      case (w.net_state)
        slpg_pkg::NET_BOOT: if (slow) begin
          r = 8'd90;
          g = 8'd55;
        end
        slpg_pkg::NET_BUTTON: begin
          // triangle: rise over 700 ms, fall over the next 700 ms
          ph = w.now_ms % 32'd1400;
          lvl = (ph < 700) ? (ph * 255 / 700) : ((32'd1400 - ph) * 255 / 700);
          r = 8'(32'd150 * lvl / 255);
          b = r;
        end
        slpg_pkg::NET_STATION: b = slow ? 8'd110 : 8'd10;
        slpg_pkg::NET_PROV: if (slow) begin
          g = 8'd130;
          b = 8'd130;
        end
        slpg_pkg::NET_ERROR: if (slow) r = 8'd140;
        default: lit = 1'b0;
      endcase
    end
    if (!lit) return;
    c.red = scale_level(r);
    c.green = scale_level(g);
    c.blue = scale_level(b);
    // drop repeats of the stored colour
    if (shown_valid && c == shown) return;
    shown = c;
    shown_valid = 1'b1;
    colours_due.push_back(c);
  endtask

  task automatic queue_word(input logic f, input logic [31:0] t, input logic [2:0] net,
                            input logic cl, input logic off);
    led_word_t w;
    w.func = f;
    w.now_ms = t;
    w.net_state = net;
    w.client = cl;
    w.offline = off;
    words_to_send.push_back(w);
  endtask

  task automatic queue_random();
    int unsigned roll;
    for (int n = 0; n < PHASE_WORDS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) sim_ms = $urandom();
      else if (roll < 10) sim_ms += $urandom_range(200, 5000);
      else sim_ms += $urandom_range(0, 80);
      if ($urandom_range(0, 99) < 15) begin
        queue_word(slpg_pkg::FUNC_ACTIVITY, sim_ms - $urandom_range(0, 3), 3'($urandom()),
                   1'($urandom()), 1'($urandom()));
      end else begin
        queue_word(slpg_pkg::FUNC_RENDER, sim_ms,
                   ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4)),
                   $urandom_range(0, 9) < 3, $urandom_range(0, 9) < 2);
      end
    end
  endtask

  task automatic wait_drained();
    while (words_to_send.size() != 0 || item_ch.valid || colours_due.size() != 0)
      @(posedge clk);
    // renders with no result may still be in the divider
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_and_verify(input logic [slpg_pkg::ADDR_W-1:0] addr,
                                  input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == BRIGHT_ADDR) bright_lvl = data[7:0];
    // read back brightness
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= BRIGHT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(bright_lvl)) begin
      $error("brightness: expected %0d, got %0d", bright_lvl, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Word driver
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) predict_colour(in_flight);
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left > 0 || words_to_send.size() == 0) begin
          if (gap_left > 0) gap_left--;
          item_ch.valid <= 1'b0;
        end else begin
          in_flight = words_to_send.pop_front();
          item_ch.valid <= 1'b1;
          item_ch.func <= in_flight.func;
          item_ch.now_ms <= in_flight.now_ms;
          item_ch.net_state <= in_flight.net_state;
          item_ch.client_connected <= in_flight.client;
          item_ch.offline_mode <= in_flight.offline;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Colour monitor with its own stall pattern
  always @(posedge clk) begin
    if (rst) begin
      colour_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (colour_ch.valid && colour_ch.ready) begin
        if (colours_due.size() == 0) begin
          $error("colour word with none expected: red %0d green %0d blue %0d",
                 colour_ch.red, colour_ch.green, colour_ch.blue);
          errors++;
        end else begin
          want = colours_due.pop_front();
          check_level("red", want.red, colour_ch.red);
          check_level("green", want.green, colour_ch.green);
          check_level("blue", want.blue, colour_ch.blue);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        colour_ch.ready <= 1'b0;
      end else begin
        colour_ch.ready <= 1'b1;
        case (cycle_count[11:10])
          2'd0: ;
          2'd1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
          2'd2: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(4, 40);
          default: if ($urandom_range(0, 1) == 0) stall_left = 1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [7:0] levels [6];
    levels = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd0, 8'd254};
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = BRIGHT_ADDR;
    pwdata = '0;
    item_ch.valid = 1'b0;
    item_ch.func = slpg_pkg::FUNC_RENDER;
    item_ch.now_ms = '0;
    item_ch.net_state = slpg_pkg::NET_BOOT;
    item_ch.client_connected = 1'b0;
    item_ch.offline_mode = 1'b0;
    colour_ch.ready = 1'b0;
    bright_lvl = slpg_pkg::BRIGHT_RESET;
    activity_ms = '0;
    shown = '0;
    shown_valid = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // first render after reset emits even black; a repeat does not
    queue_word(slpg_pkg::FUNC_RENDER, 32'd0, slpg_pkg::NET_BOOT, 1'b0, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd100, slpg_pkg::NET_BOOT, 1'b0, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd500, slpg_pkg::NET_BOOT, 1'b0, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd0, slpg_pkg::NET_BUTTON, 1'b0, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd350, slpg_pkg::NET_BUTTON, 1'b0, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd700, slpg_pkg::NET_BUTTON, 1'b0, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd1050, slpg_pkg::NET_BUTTON, 1'b0, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'hFFFF_FFFF, slpg_pkg::NET_BUTTON, 1'b0, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd0, slpg_pkg::NET_STATION, 1'b0, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd500, slpg_pkg::NET_STATION, 1'b0, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd500, slpg_pkg::NET_PROV, 1'b0, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd500, slpg_pkg::NET_ERROR, 1'b0, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd0, slpg_pkg::NET_ERROR, 1'b0, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd777, 3'd5, 1'b0, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd777, 3'd6, 1'b0, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd777, 3'd7, 1'b0, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd0, slpg_pkg::NET_BOOT, 1'b0, 1'b1);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd150, slpg_pkg::NET_BOOT, 1'b0, 1'b1);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd250, slpg_pkg::NET_ERROR, 1'b0, 1'b1);
    queue_word(slpg_pkg::FUNC_RENDER, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1);
    // activity ignores the other fields
    queue_word(slpg_pkg::FUNC_ACTIVITY, 32'd1000, 3'd7, 1'b1, 1'b1);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd1020, slpg_pkg::NET_BOOT, 1'b1, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd1149, slpg_pkg::NET_BOOT, 1'b1, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd1150, slpg_pkg::NET_BOOT, 1'b1, 1'b0);
    queue_word(slpg_pkg::FUNC_ACTIVITY, 32'hFFFF_FFF0, slpg_pkg::NET_BOOT, 1'b0, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'd5, slpg_pkg::NET_ERROR, 1'b1, 1'b0);
    queue_word(slpg_pkg::FUNC_RENDER, 32'hFFFF_FFE0, slpg_pkg::NET_ERROR, 1'b1, 1'b0);
    sim_ms = $urandom();
    queue_random();
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) write_and_verify(UNMAPPED_ADDR, $urandom());
      write_and_verify(BRIGHT_ADDR,
                       {24'($urandom()), (p == 4) ? 8'($urandom()) : levels[p]});
      queue_random();
      wait_drained();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
